[src/fbe_pkg.sv]
// ----------------------------------------------------------------------------
// FASTQ base encoder package
// Shared constants, line and header states, and the result record.
// ----------------------------------------------------------------------------
package fbe_pkg;

  localparam logic [7:0] READ_LEN   = 8'd128;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_GT    = 8'h3e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [1:0] COMP_MASK  = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SEQ    = 2'd1,
    PH_PLUS   = 2'd2,
    PH_QUAL   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    HP_FIRST  = 2'd0,
    HP_SECOND = 2'd1,
    HP_DIGITS = 2'd2,
    HP_DONE   = 2'd3
  } hdr_t;

  typedef struct packed {
    logic [7:0] fwd_pos;
    logic [1:0] fwd_code;
    logic [7:0] rev_pos;
    logic [1:0] rev_code;
    logic       is_padding;
    logic       last_of_read;
    logic       short_line;
  } res_t;

endpackage

[src/fbe_parser.sv]
// ----------------------------------------------------------------------------
// FASTQ base encoder line parser
// Tracks the line kind and header offset, and forms the result of each sequence-line byte within the read length.
// ----------------------------------------------------------------------------
module fbe_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         take,
  input  logic [7:0]   byte_in,
  output logic         res_valid,
  output fbe_pkg::res_t res
);
  import fbe_pkg::*;

  phase_t     phase_r, phase_nxt;
  hdr_t       hdr_r, hdr_nxt;
  logic       fasta_r, fasta_nxt;
  logic [7:0] column_r, column_nxt;
  logic [7:0] skip_r, skip_nxt;

  logic        is_nl;
  logic        is_digit;
  logic [11:0] acc;
  logic [7:0]  lim;
  logic [1:0]  code;
  logic        col_live;

  assign is_nl    = (byte_in == CHAR_NL);
  assign is_digit = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
  assign acc      = {4'd0, skip_r} * 12'd10 + {4'd0, byte_in - CHAR_ZERO};
  assign lim      = READ_LEN - skip_r;
  assign code     = byte_in[2:1];
  assign col_live = (column_r < READ_LEN);

  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    fasta_nxt  = fasta_r;
    column_nxt = column_r;
    skip_nxt   = skip_r;
    case (phase_r)
      PH_HEADER: begin
        if (hdr_r == HP_FIRST) begin
          skip_nxt  = 8'd0;
          fasta_nxt = (byte_in == CHAR_GT);
          hdr_nxt   = HP_SECOND;
        end else if (!is_nl && hdr_r == HP_SECOND) begin
          hdr_nxt = (byte_in == CHAR_GT) ? HP_DIGITS : HP_DONE;
        end else if (!is_nl && hdr_r == HP_DIGITS) begin
          if (is_digit) begin
            skip_nxt = (acc > {4'd0, READ_LEN}) ? READ_LEN : acc[7:0];
          end else begin
            hdr_nxt = HP_DONE;
          end
        end
        if (is_nl) begin
          phase_nxt  = PH_SEQ;
          column_nxt = 8'd0;
        end
      end
      PH_SEQ: begin
        if (is_nl) begin
          column_nxt = 8'd0;
          hdr_nxt    = HP_FIRST;
          phase_nxt  = fasta_r ? PH_HEADER : PH_PLUS;
        end else if (col_live) begin
          column_nxt = column_r + 8'd1;
        end
      end
      PH_PLUS: begin
        if (is_nl) begin
          phase_nxt = PH_QUAL;
        end
      end
      PH_QUAL: begin
        if (is_nl) begin
          phase_nxt = PH_HEADER;
          hdr_nxt   = HP_FIRST;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (phase_r == PH_SEQ && col_live) begin
      res_valid = 1'b1;
      if (is_nl) begin
        res.short_line = 1'b1;
      end else begin
        res.fwd_pos      = column_r;
        res.last_of_read = (column_r == READ_LEN - 8'd1);
        if (column_r < lim) begin
          res.fwd_code = code;
          res.rev_pos  = lim - 8'd1 - column_r;
          res.rev_code = code ^ COMP_MASK;
        end else begin
          res.rev_pos    = column_r;
          res.is_padding = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hdr_r    <= HP_FIRST;
      fasta_r  <= 1'b0;
      column_r <= 8'd0;
      skip_r   <= 8'd0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      hdr_r    <= hdr_nxt;
      fasta_r  <= fasta_nxt;
      column_r <= column_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

[src/fbe_out_skid.sv]
// ----------------------------------------------------------------------------
// FASTQ base encoder result stage
// Result register with a skid entry that takes a result while the output stalls.
// ----------------------------------------------------------------------------
module fbe_out_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fbe_pkg::res_t push_data,
  input  logic          out_stall,
  output logic          out_valid,
  output fbe_pkg::res_t out_data,
  output logic          full
);
  import fbe_pkg::*;

  logic main_v_r;
  logic skid_v_r;
  res_t main_d_r;
  res_t skid_d_r;
  logic free;

  assign free      = !main_v_r || !out_stall;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;
  assign full      = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (free) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      main_d_r <= skid_v_r ? skid_d_r : push_data;
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

endmodule

[src/fastq_base_encode_revcomp.sv]
// ----------------------------------------------------------------------------
// FASTQ base encoder with reverse complement
// Parses a FASTA or FASTQ byte stream and emits 2-bit base codes.
// ----------------------------------------------------------------------------
// One byte is taken in every cycle while input is not stalled, and each
// result is registered in the result stage; a two-entry result stage lets
// input continue through an output stall while its skid entry is free, and
// input stalls only when both entries are occupied.
module fastq_base_encode_revcomp (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_fwd_pos,
  output logic [1:0] out_fwd_code,
  output logic [7:0] out_rev_pos,
  output logic [1:0] out_rev_code,
  output logic       out_is_padding,
  output logic       out_last_of_read,
  output logic       out_short_line
);
  import fbe_pkg::*;

  logic take;
  logic res_valid;
  logic full;
  res_t res;
  res_t out_data;

  assign in_stall = full;
  assign take     = in_valid && !full;

  fbe_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .byte_in   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  fbe_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && res_valid),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (full)
  );

  assign out_fwd_pos      = out_data.fwd_pos;
  assign out_fwd_code     = out_data.fwd_code;
  assign out_rev_pos      = out_data.rev_pos;
  assign out_rev_code     = out_data.rev_code;
  assign out_is_padding   = out_data.is_padding;
  assign out_last_of_read = out_data.last_of_read;
  assign out_short_line   = out_data.short_line;

endmodule
